@@ src/assert_macros.svh @@
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ src/vtb_pkg.sv @@
package vtb_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int FILL_W    = $clog2(NUM_SLOTS + 1);
    localparam int PIN_W     = 4;
    localparam int TMO_W     = 32;
    localparam int MASK_W    = 16;
    localparam int FLAGS_W   = 16;
    localparam int USED_W    = 5;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // token walking down the row of cells during a tick
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
    } vtb_token_t;

    // slot setup broadcast on an add
    typedef struct packed {
        logic             load;
        logic [TMO_W-1:0] timeout;
        logic [PIN_W-1:0] pin;
        logic             repeat_mode;
    } vtb_load_t;

endpackage

@@ src/vtb_cell.sv @@
module vtb_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  vtb_pkg::vtb_load_t  load,
    input  vtb_pkg::vtb_token_t token_in,
    output vtb_pkg::vtb_token_t token_out,
    output logic               flag
);
    import vtb_pkg::*;

    logic [TMO_W-1:0]  timeout_reg;
    logic [TMO_W-1:0]  count_reg, count_next;
    logic [PIN_W-1:0]  pin_reg;
    logic              repeat_reg;
    logic              enable_reg, enable_next;
    logic              flag_reg, flag_next;
    logic              token_valid_reg;
    logic [MASK_W-1:0] token_mask_reg;
    vtb_token_t        token_next;
    logic              expire;

    assign expire = count_reg >= timeout_reg;

    always_comb
    begin
        count_next  = count_reg;
        enable_next = enable_reg;
        flag_next   = flag_reg;
        token_next  = token_in;
        if (load.load)
        begin
            count_next  = '0;
            enable_next = 1'b1;
            flag_next   = 1'b0;
        end
        else if (token_in.valid && enable_reg)
        begin
            if (expire)
            begin
                flag_next       = 1'b1;
                token_next.mask = token_in.mask ^ (MASK_W'(1) << pin_reg);
                if (repeat_reg)
                    count_next = '0;
                else
                    enable_next = 1'b0;
            end
            else
            begin
                count_next = count_reg + TMO_W'(1);
                flag_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            flag_reg        <= 1'b0;
            token_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg      <= enable_next;
            flag_reg        <= flag_next;
            token_valid_reg <= token_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        token_mask_reg <= token_next.mask;
        count_reg      <= count_next;
        if (load.load)
        begin
            timeout_reg <= load.timeout;
            pin_reg     <= load.pin;
            repeat_reg  <= load.repeat_mode;
        end
    end

    assign token_out.valid = token_valid_reg;
    assign token_out.mask  = token_mask_reg;
    assign flag            = flag_reg;

endmodule

@@ src/virtual_timer_bank.sv @@
// virtual_timer_bank: sixteen software timer slots held in a row of cells.
// input stream s_*: tuser = operation (0 tick, 1 add); tdata carries the
// timeout, pin and repeat mode of an add and is ignored on a tick.
// output stream m_*: one result beat per input beat, in order.
// an add beat writes the next free slot (or is refused when the bank is
// full); its result passes through the hold state to the output register.
// a tick beat sends a token down the row, one cell per cycle; each cell
// updates its slot and folds its pin toggle into the token. the result
// is taken from the token at the end of the row, then passes through the
// hold state to the output register.
// one item is in flight at a time; s_tready is high only while the row is
// free. a finished result sits in the output register; if the receiver
// stalls, a further finished result waits inside until that register drains.
// reset empties the bank, clears all flags and drops any pending beat.
module virtual_timer_bank (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // timeout_count[31:0], pin_number[35:32], repeat_mode[36], zero pad
    input  logic [vtb_pkg::S_DATA_W-1:0] s_tdata,
    // operation[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // toggle_mask[15:0], expired_flags[31:16], add_accepted[32],
    // slots_used[37:33], zero pad
    output logic [vtb_pkg::M_DATA_W-1:0] m_tdata
);
    import vtb_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic                acc_reg, acc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                s_beat, is_add, add_ok, out_free;
    vtb_token_t          chain [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] cell_flag;
    logic [FLAGS_W-1:0]  flags;

    assign s_tready = state_reg == ST_IDLE;
    assign s_beat   = s_tvalid && s_tready;
    assign is_add   = s_tuser == OP_ADD;
    assign add_ok   = s_beat && is_add && (fill_reg < FILL_W'(NUM_SLOTS));
    assign out_free = !m_tvalid_reg || m_tready;

    assign chain[0].valid = s_beat && !is_add;
    assign chain[0].mask  = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            vtb_load_t ld;
            assign ld.load        = add_ok && (fill_reg == FILL_W'(g));
            assign ld.timeout     = s_tdata[TMO_W-1:0];
            assign ld.pin         = s_tdata[TMO_W+PIN_W-1:TMO_W];
            assign ld.repeat_mode = s_tdata[TMO_W+PIN_W];
            vtb_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (ld),
                .token_in (chain[g]),
                .token_out(chain[g+1]),
                .flag     (cell_flag[g])
            );
        end
        for (g = 0; g < FLAGS_W; g++)
        begin : g_flag
            if (g < NUM_SLOTS)
            begin : g_on
                assign flags[g] = cell_flag[g];
            end
            else
            begin : g_off
                assign flags[g] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        mask_next     = mask_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                begin
                    mask_next = '0;
                    acc_next  = add_ok;
                    if (add_ok)
                        fill_next = fill_reg + FILL_W'(1);
                    state_next = is_add ? ST_HOLD : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (chain[NUM_SLOTS].valid)
                begin
                    mask_next  = chain[NUM_SLOTS].mask;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_DATA_W - MASK_W - FLAGS_W - 1 - USED_W)'(0),
                                     USED_W'(fill_reg), acc_reg, flags, mask_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_reg > FILL_W'(NUM_SLOTS),
                  "fill level overflow")
    `ASSERT_PROP(a_tail_walk, clk, rst_n, chain[NUM_SLOTS].valid |-> state_reg == ST_WALK,
                 "token out of walk")
    `ASSERT_PROP(a_fill_step, clk, rst_n,
                 add_ok |=> fill_reg == $past(fill_reg) + FILL_W'(1),
                 "fill did not advance")
    `ASSERT_PROP(a_add_nomask, clk, rst_n,
                 m_tvalid && m_tdata[MASK_W+FLAGS_W] |-> m_tdata[MASK_W-1:0] == '0,
                 "add with toggles")

endmodule
